/* src/sriex_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sriex_pkg
// shared types and constants of the instruction executor
// ----------------------------------------------------------------------------
package sriex_pkg;

  localparam int unsigned RegCount = 32;
  localparam int unsigned MemWords = 1024;
  localparam int unsigned MemAw    = $clog2(MemWords);

  typedef enum logic [4:0] {
    OP_STOP  = 5'd0,  OP_ADD  = 5'd1,  OP_SUB   = 5'd2,  OP_MULT  = 5'd3,
    OP_DIV   = 5'd4,  OP_AND  = 5'd5,  OP_OR    = 5'd6,  OP_XOR   = 5'd7,
    OP_SHL   = 5'd8,  OP_SHR  = 5'd9,  OP_SLT   = 5'd10, OP_SLE   = 5'd11,
    OP_SEQ   = 5'd12, OP_LOAD = 5'd13, OP_STORE = 5'd14, OP_JMP   = 5'd15,
    OP_BRAZ  = 5'd16, OP_BRANZ = 5'd17, OP_SCALL = 5'd18
  } opcode_e;

  localparam logic [2:0] ErrNone   = 3'd0;
  localparam logic [2:0] ErrReg    = 3'd1;
  localparam logic [2:0] ErrMem    = 3'd2;
  localparam logic [2:0] ErrJump   = 3'd3;
  localparam logic [2:0] ErrDivZ   = 3'd4;
  localparam logic [2:0] ErrOpcode = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic load_instr;   // capture instruction word
    logic read_ops;     // read register operands
    logic exec;         // evaluate ALU ops, start divider or memory
    logic div_step;     // one divider iteration
    logic finish;       // commit and build result
    logic out_take;     // result taken downstream
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_div;       // instruction needs the divider
    logic is_mem;       // instruction needs the memory read state
    logic div_done;
    logic halted;
    logic clearing;     // data memory clear pass after reset in progress
  } dp_sts_t;

endpackage

/* src/sriex_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sriex_datapath
// register file, data memory, alu, serial divider and pc of the executor
// ----------------------------------------------------------------------------
module sriex_datapath import sriex_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic [31:0] instr_word_i,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  output logic [15:0] next_pc_o,
  output logic        halted_o,
  output logic [2:0]  error_code_o,
  output logic        reg_written_o,
  output logic [4:0]  written_index_o,
  output logic [31:0] written_value_o
);

  logic [31:0] instr_q;
  logic [15:0] pc_q, plen_q;
  logic        run_q;
  logic [31:0] rf_q [RegCount];
  logic [31:0] mem_q [MemWords];
  logic [RegCount-1:0] rf_vld_q;
  logic        clr_q;
  logic [MemAw-1:0] clr_addr_q;
  logic [31:0] a_q, b_q, src_q;
  logic        err_reg_q;
  logic [2:0]  err_q;
  logic        wr_q;
  logic [4:0]  widx_q;
  logic [31:0] wval_q;
  logic [15:0] npc_q;
  logic        st_q;
  logic [MemAw-1:0] addr_q;
  logic [31:0] memrd_q;
  logic [31:0] quo_q, rem_q;
  logic [5:0]  dcnt_q;

  logic [4:0]  op, ra, rb;
  logic        fl;
  logic [15:0] imm;
  assign op  = instr_q[31:27];
  assign ra  = instr_q[26:22];
  assign rb  = instr_q[21:17];
  assign fl  = instr_q[16];
  assign imm = instr_q[15:0];

  function automatic logic rok(logic [15:0] idx);
    return idx < 16'(RegCount);
  endfunction

  function automatic logic [31:0] rfrd(logic [31:0] d, logic v);
    return v ? d : 32'd0;
  endfunction

  // operand usage decode
  logic need_a, need_b, bsel, err_reg;
  always_comb begin
    need_a = 1'b0;
    need_b = 1'b0;
    bsel   = 1'b0;
    if (op >= OP_ADD && op <= OP_XOR) begin
      need_a = 1'b1; bsel = fl;
    end else if (op == OP_SHL || op == OP_SHR) begin
      need_a = 1'b1;
    end else if (op >= OP_SLT && op <= OP_STORE) begin
      need_a = 1'b1; bsel = fl;
    end else if (op >= OP_JMP && op <= OP_BRANZ) begin
      need_b = 1'b1;
    end
    err_reg = (need_a && (!rok(16'(ra)) || !rok(16'(rb)))) ||
              (need_b && !rok(16'(ra))) || (bsel && !rok(imm));
  end

  logic [4:0] asrc;
  assign asrc = (op <= OP_SHR) ? rb : ra;

  assign sts_o.is_div   = (op == OP_DIV) && !err_reg_q && (b_q != 32'd0) && run_q;
  assign sts_o.is_mem   = (op == OP_LOAD) && !err_reg_q && run_q;
  assign sts_o.div_done = (dcnt_q == 6'd0);
  assign sts_o.halted   = !run_q;
  assign sts_o.clearing = clr_q;

  // combinational execute
  logic [32:0] addr_sum;
  assign addr_sum = {1'b0, a_q} + {1'b0, b_q};
  logic [63:0] prod;
  assign prod = a_q * b_q;
  logic [2:0]  ex_err;
  logic        ex_wr, ex_st;
  logic [4:0]  ex_widx;
  logic [31:0] ex_wval;
  logic [15:0] ex_npc;
  always_comb begin
    ex_err = ErrNone; ex_wr = 1'b0; ex_st = 1'b0;
    ex_widx = ra; ex_wval = 32'd0; ex_npc = pc_q + 16'd1;
    if (err_reg_q) begin
      ex_err = ErrReg;
    end else begin
      unique case (op)
        OP_STOP:  ;
        OP_ADD:   begin ex_wr = 1'b1; ex_wval = a_q + b_q; end
        OP_SUB:   begin ex_wr = 1'b1; ex_wval = a_q - b_q; end
        OP_MULT:  begin ex_wr = 1'b1; ex_wval = prod[31:0]; end
        OP_DIV:   if (b_q == 32'd0) ex_err = ErrDivZ;
        OP_AND:   begin ex_wr = 1'b1; ex_wval = a_q & b_q; end
        OP_OR:    begin ex_wr = 1'b1; ex_wval = a_q | b_q; end
        OP_XOR:   begin ex_wr = 1'b1; ex_wval = a_q ^ b_q; end
        OP_SHL:   begin
          ex_wr = 1'b1; ex_wval = (imm >= 16'd32) ? 32'd0 : a_q << imm[4:0];
        end
        OP_SHR:   begin
          ex_wr = 1'b1; ex_wval = (imm >= 16'd32) ? 32'd0 : a_q >> imm[4:0];
        end
        OP_SLT:   begin ex_wr = 1'b1; ex_widx = rb; ex_wval = {31'd0, a_q < b_q}; end
        OP_SLE:   begin ex_wr = 1'b1; ex_widx = rb; ex_wval = {31'd0, a_q <= b_q}; end
        OP_SEQ:   begin ex_wr = 1'b1; ex_widx = rb; ex_wval = {31'd0, a_q == b_q}; end
        OP_LOAD, OP_STORE: begin
          if (addr_sum >= 33'(MemWords)) ex_err = ErrMem;
          else if (op == OP_LOAD) begin ex_wr = 1'b1; ex_widx = rb; end
          else ex_st = 1'b1;
        end
        OP_JMP:   begin
          if (imm >= plen_q) ex_err = ErrJump;
          else begin
            ex_wr = 1'b1; ex_wval = {16'd0, pc_q} + 32'd1; ex_npc = imm;
          end
        end
        OP_BRAZ, OP_BRANZ: begin
          if ((op == OP_BRAZ) == (a_q == 32'd0)) begin
            if (imm >= plen_q) ex_err = ErrJump;
            else ex_npc = imm;
          end
        end
        OP_SCALL: ;
        default:  ex_err = ErrOpcode;
      endcase
    end
  end

  // restoring divider step
  logic [32:0] dtrial;
  assign dtrial = {rem_q, quo_q[31]} - {1'b0, b_q};

  // sequential state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q       <= '0;
      plen_q     <= '0;
      run_q      <= 1'b1;
      rf_vld_q   <= '0;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      dcnt_q     <= '0;
    end else begin
      if (cfg_we_i) plen_q <= cfg_wdata_i;
      // memory clear pass, one word per cycle
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == MemAw'(MemWords - 1)) clr_q <= 1'b0;
      end
      if (cmd_i.exec && sts_o.is_div) dcnt_q <= 6'd32;
      else if (cmd_i.div_step && dcnt_q != 6'd0) dcnt_q <= dcnt_q - 6'd1;
      if (cmd_i.finish && run_q) begin
        pc_q <= npc_q;
        if (op == OP_STOP && err_q == ErrNone) run_q <= 1'b0;
        if (wr_q) rf_vld_q[widx_q] <= 1'b1;
      end
    end
  end

  // payload registers
  logic [31:0] fin_wval;
  always_comb begin
    fin_wval = wval_q;
    if (op == OP_DIV) fin_wval = quo_q;
    else if (op == OP_LOAD) fin_wval = memrd_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_instr) instr_q <= instr_word_i;
    if (cmd_i.read_ops) begin
      a_q       <= rfrd(rf_q[asrc], rf_vld_q[asrc]);
      b_q       <= bsel ? rfrd(rf_q[imm[4:0]], rf_vld_q[imm[4:0]])
                        : {16'd0, imm};
      src_q     <= rfrd(rf_q[rb], rf_vld_q[rb]);
      err_reg_q <= err_reg;
    end
    if (cmd_i.exec) begin
      err_q  <= ex_err;
      wr_q   <= ex_wr || (op == OP_DIV && ex_err == ErrNone && !err_reg_q);
      widx_q <= ex_widx;
      wval_q <= ex_wval;
      npc_q  <= ex_npc;
      st_q   <= ex_st;
      addr_q <= addr_sum[MemAw-1:0];
      quo_q  <= a_q;
      rem_q  <= '0;
    end
    if (cmd_i.div_step && dcnt_q != 6'd0) begin
      if (!dtrial[32]) begin
        rem_q <= dtrial[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= {rem_q[30:0], quo_q[31]};
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
    // memory port: read during load cycle, clear after reset, write on commit
    memrd_q <= mem_q[addr_sum[MemAw-1:0]];
    if (clr_q) mem_q[clr_addr_q] <= '0;
    else if (cmd_i.finish && run_q && st_q) mem_q[addr_q] <= src_q;
    if (cmd_i.finish && run_q && wr_q) rf_q[widx_q] <= fin_wval;
    if (cmd_i.finish) begin
      if (!run_q) begin
        next_pc_o <= pc_q; halted_o <= 1'b1; error_code_o <= ErrNone;
        reg_written_o <= 1'b0; written_index_o <= '0; written_value_o <= '0;
      end else begin
        next_pc_o       <= npc_q;
        halted_o        <= (op == OP_STOP && err_q == ErrNone);
        error_code_o    <= err_q;
        reg_written_o   <= wr_q;
        written_index_o <= wr_q ? widx_q : 5'd0;
        written_value_o <= wr_q ? fin_wval : 32'd0;
      end
    end
  end

  logic unused;
  assign unused = cmd_i.out_take;

endmodule

/* src/sriex_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sriex_ctrl
// sequencing state machine and handshake of the executor
// ----------------------------------------------------------------------------
module sriex_ctrl import sriex_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_READ = 6'b000010, S_EXEC = 6'b000100,
    S_DIV  = 6'b001000, S_MEM  = 6'b010000, S_FIN  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   ovld_q;

  assign in_ready_o  = (state_q == S_IDLE) && !sts_i.clearing &&
                       (!ovld_q || out_ready_i);
  assign out_valid_o = ovld_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.load_instr = in_valid_i && in_ready_o;
    cmd_o.read_ops   = (state_q == S_READ);
    cmd_o.exec       = (state_q == S_EXEC);
    cmd_o.div_step   = (state_q == S_DIV);
    cmd_o.finish     = (state_q == S_FIN);
    cmd_o.out_take   = ovld_q && out_ready_i;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i && in_ready_o) state_d = S_READ;
      S_READ: state_d = S_EXEC;
      S_EXEC: begin
        if (sts_i.is_div)      state_d = S_DIV;
        else if (sts_i.is_mem) state_d = S_MEM;
        else                   state_d = S_FIN;
      end
      S_DIV:  if (sts_i.div_done) state_d = S_FIN;
      S_MEM:  state_d = S_FIN;
      S_FIN:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // input is accepted only while the output slot is free or being taken, so finish never overwrites
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FIN)    ovld_q <= 1'b1;
      else if (cmd_o.out_take) ovld_q <= 1'b0;
    end
  end

  logic unused;
  assign unused = sts_i.halted;

endmodule

/* src/simple_risc_instruction_executor_core.sv */
`timescale 1ns / 1ps
// Sequence: after accept, read operands, execute, then divide or memory read
// if needed, then finish, which registers the result; one instruction at a time.
// The serial restoring divider (32 steps) sets the worst case.
// Reset: asynchronous active low; registers read as zero, pc 0, running,
// program length 0; the data memory is cleared word by word after reset,
// during which no instruction is accepted.
// ----------------------------------------------------------------------------
// simple_risc_instruction_executor_core
// top level: controller plus datapath of the 32-bit instruction executor
// ----------------------------------------------------------------------------
module simple_risc_instruction_executor_core import sriex_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] instr_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] next_pc_o,
  output logic        halted_o,
  output logic [2:0]  error_code_o,
  output logic        reg_written_o,
  output logic [4:0]  written_index_o,
  output logic [31:0] written_value_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencing
  sriex_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  // execution
  sriex_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .instr_word_i,
    .cmd_i(cmd), .sts_o(sts), .next_pc_o, .halted_o, .error_code_o,
    .reg_written_o, .written_index_o, .written_value_o
  );

endmodule

/* src/sriex_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sriex_checker
// port level checks of the executor, bound to the top level
// ----------------------------------------------------------------------------
module sriex_checker import sriex_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        halted_o,
  input logic [2:0]  error_code_o,
  input logic        reg_written_o,
  input logic [4:0]  written_index_o,
  input logic [31:0] written_value_o
);

  // a pending result holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(written_value_o))
    else $error("result changed while stalled");

  // after an accept, in_ready_o is low in the next cycle
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // an error never comes with a register write
  a_err_nowr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != ErrNone |-> !reg_written_o)
    else $error("write reported with error");

  // no write fields without a write
  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !reg_written_o |-> written_index_o == 5'd0 &&
    written_value_o == 32'd0)
    else $error("write fields set without write");

  // a halted result never reports an error
  a_halt_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && halted_o |-> error_code_o == ErrNone)
    else $error("error reported while halted");

endmodule

bind simple_risc_instruction_executor_core sriex_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .halted_o, .error_code_o, .reg_written_o, .written_index_o, .written_value_o
);

/* test/tb_simple_risc_instruction_executor_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_simple_risc_instruction_executor_core
// self-checking bench: directed and random instruction streams under random
// back-pressure, with an instruction-level predictor as scoreboard
// ----------------------------------------------------------------------------
module tb_simple_risc_instruction_executor_core;
  import sriex_pkg::*;

  typedef struct {
    logic [15:0] next_pc;
    logic        halted;
    logic [2:0]  error_code;
    logic        reg_written;
    logic [4:0]  written_index;
    logic [31:0] written_value;
  } exec_result_t;

  // instruction predictor plus queue of predicted results
  class exec_scoreboard;
    logic [31:0]  regs [RegCount];
    logic [31:0]  dmem [MemWords];
    logic [15:0]  pc;
    logic         running;
    logic [15:0]  prog_len;
    exec_result_t pending_q [$];
    int           fail_count;

    function void clear_state();
      foreach (regs[i]) regs[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      pc         = '0;
      running    = 1'b1;
      prog_len   = '0;
      fail_count = 0;
    endfunction

    // execute one accepted instruction and queue its result
    function void note_instr(logic [31:0] w);
      logic [4:0]   op;
      logic [4:0]   ra;
      logic [4:0]   rb;
      logic         fl;
      logic [15:0]  imm;
      logic [31:0]  a;
      logic [31:0]  b;
      logic [32:0]  addr;
      logic [15:0]  npc;
      exec_result_t r;
      op  = w[31:27];
      ra  = w[26:22];
      rb  = w[21:17];
      fl  = w[16];
      imm = w[15:0];
      r   = '{default: '0};
      if (!running) begin
        r.next_pc = pc;
        r.halted  = 1'b1;
        pending_q.push_back(r);
        return;
      end
      npc = pc + 16'd1;
      b   = {16'd0, imm};
      a   = '0;
      // register operand b, only for ops that honor the flag
      if (fl && (op inside {[OP_ADD:OP_XOR], [OP_SLT:OP_STORE]})) begin
        if (imm >= RegCount) r.error_code = ErrReg;
        else b = regs[imm];
      end
      if (op inside {[OP_ADD:OP_SHR]}) a = regs[rb];
      else if (op inside {[OP_SLT:OP_BRANZ]}) a = regs[ra];
      if (r.error_code == ErrNone) begin
        case (op)
          OP_STOP:  running = 1'b0;
          OP_ADD:   begin r.reg_written = 1; r.written_index = ra; r.written_value = a + b; end
          OP_SUB:   begin r.reg_written = 1; r.written_index = ra; r.written_value = a - b; end
          OP_MULT:  begin r.reg_written = 1; r.written_index = ra; r.written_value = a * b; end
          OP_DIV: begin
            if (b == 0) r.error_code = ErrDivZ;
            else begin
              r.reg_written = 1; r.written_index = ra; r.written_value = a / b;
            end
          end
          OP_AND:   begin r.reg_written = 1; r.written_index = ra; r.written_value = a & b; end
          OP_OR:    begin r.reg_written = 1; r.written_index = ra; r.written_value = a | b; end
          OP_XOR:   begin r.reg_written = 1; r.written_index = ra; r.written_value = a ^ b; end
          OP_SHL: begin
            r.reg_written = 1; r.written_index = ra;
            r.written_value = (imm >= 32) ? '0 : a << imm;
          end
          OP_SHR: begin
            r.reg_written = 1; r.written_index = ra;
            r.written_value = (imm >= 32) ? '0 : a >> imm;
          end
          OP_SLT:   begin r.reg_written = 1; r.written_index = rb; r.written_value = a < b; end
          OP_SLE:   begin r.reg_written = 1; r.written_index = rb; r.written_value = a <= b; end
          OP_SEQ:   begin r.reg_written = 1; r.written_index = rb; r.written_value = a == b; end
          OP_LOAD, OP_STORE: begin
            // address sum does not wrap
            addr = {1'b0, a} + {1'b0, b};
            if (addr >= MemWords) r.error_code = ErrMem;
            else if (op == OP_LOAD) begin
              r.reg_written = 1; r.written_index = rb; r.written_value = dmem[addr];
            end else dmem[addr] = regs[rb];
          end
          OP_JMP: begin
            if (imm >= prog_len) r.error_code = ErrJump;
            else begin
              r.reg_written = 1; r.written_index = ra;
              r.written_value = {16'd0, pc} + 32'd1;
              npc = imm;
            end
          end
          OP_BRAZ, OP_BRANZ: begin
            // untaken branch never fails
            if ((op == OP_BRAZ) == (a == 0)) begin
              if (imm >= prog_len) r.error_code = ErrJump;
              else npc = imm;
            end
          end
          OP_SCALL: ;
          default:  r.error_code = ErrOpcode;
        endcase
      end
      if (r.reg_written) regs[r.written_index] = r.written_value;
      pc        = npc;
      r.next_pc = npc;
      r.halted  = !running;
      pending_q.push_back(r);
    endfunction

    function void check_result(exec_result_t act);
      exec_result_t exp_r;
      if (pending_q.size() == 0) begin
        $error("unexpected result transaction, next_pc %0h", act.next_pc);
        fail_count++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (act.next_pc !== exp_r.next_pc) begin
        $error("next_pc: expected %0h, actual %0h", exp_r.next_pc, act.next_pc);
        fail_count++;
      end
      if (act.halted !== exp_r.halted) begin
        $error("halted: expected %0b, actual %0b", exp_r.halted, act.halted);
        fail_count++;
      end
      if (act.error_code !== exp_r.error_code) begin
        $error("error_code: expected %0d, actual %0d", exp_r.error_code, act.error_code);
        fail_count++;
      end
      if (act.reg_written !== exp_r.reg_written) begin
        $error("reg_written: expected %0b, actual %0b", exp_r.reg_written, act.reg_written);
        fail_count++;
      end
      if (act.written_index !== exp_r.written_index) begin
        $error("written_index: expected %0d, actual %0d",
               exp_r.written_index, act.written_index);
        fail_count++;
      end
      if (act.written_value !== exp_r.written_value) begin
        $error("written_value: expected %0h, actual %0h",
               exp_r.written_value, act.written_value);
        fail_count++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] instr_word_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] next_pc_o;
  logic        halted_o;
  logic [2:0]  error_code_o;
  logic        reg_written_o;
  logic [4:0]  written_index_o;
  logic [31:0] written_value_o;

  exec_scoreboard exec_sb;
  bit             quiet_mode;
  bit             long_hold_req;
  int             idle_cycles;

  simple_risc_instruction_executor_core i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .instr_word_i,
    .out_valid_o,
    .out_ready_i,
    .next_pc_o,
    .halted_o,
    .error_code_o,
    .reg_written_o,
    .written_index_o,
    .written_value_o
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [31:0] mk_instr(opcode_e op, int ra, int rb, bit fl, int imm);
    return {op, ra[4:0], rb[4:0], fl, imm[15:0]};
  endfunction

  // drive one instruction and hold it until the transaction completes
  task automatic send_instr(logic [31:0] w);
    in_valid_i   <= 1'b1;
    instr_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    exec_sb.note_instr(w);
  endtask

  // random gap between instructions
  task automatic sender_gap();
    if (!quiet_mode && $urandom_range(3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (exec_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_prog_len(logic [15:0] len);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    exec_sb.prog_len = len;
  endtask

  function automatic logic [31:0] rand_instr();
    logic [4:0]  op;
    logic [15:0] imm;
    int          sel;
    op  = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 19)) : 5'($urandom_range(18, 1));
    sel = $urandom_range(3);
    case (sel)
      0: imm = 16'($urandom_range(40));
      1: imm = 16'($urandom_range(1100));
      2: imm = 16'($urandom);
      default: imm = ($urandom_range(1)) ? 16'hFFFF : 16'd31;
    endcase
    return {op, 5'($urandom), 5'($urandom), 1'($urandom), imm};
  endfunction

  // result side: check transactions and apply random back-pressure
  initial begin
    exec_result_t act;
    int           stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        act = '{next_pc_o, halted_o, error_code_o, reg_written_o,
                written_index_o, written_value_o};
        exec_sb.check_result(act);
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = 300;
      end else if (stall_left == 0 && !quiet_mode && $urandom_range(4) == 0) begin
        stall_left = $urandom_range(15, 1);
      end
      if (stall_left > 0) stall_left--;
      out_ready_i <= (stall_left == 0);
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 5000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    logic [15:0] len_list [5];
    exec_sb       = new();
    exec_sb.clear_state();
    quiet_mode    = 1'b0;
    long_hold_req = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    instr_word_i  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, every opcode but stop and the special cases
    write_prog_len(16'd16);
    send_instr(mk_instr(OP_ADD,   1, 0, 0, 16'hFFFF));
    send_instr(mk_instr(OP_SUB,   2, 0, 0, 1));
    send_instr(mk_instr(OP_MULT,  3, 1, 1, 2));
    send_instr(mk_instr(OP_DIV,   4, 2, 0, 0));
    send_instr(mk_instr(OP_DIV,   5, 2, 1, 1));
    send_instr(mk_instr(OP_AND,   6, 2, 0, 16'h00F0));
    send_instr(mk_instr(OP_OR,    7, 6, 0, 16'h8001));
    send_instr(mk_instr(OP_XOR,  31, 2, 1, 31));
    send_instr(mk_instr(OP_SHL,   8, 1, 1, 31));
    send_instr(mk_instr(OP_SHL,   9, 1, 0, 32));
    send_instr(mk_instr(OP_SHR,  10, 2, 0, 40));
    send_instr(mk_instr(OP_SLT,   1, 11, 0, 16'hFFFF));
    send_instr(mk_instr(OP_SLE,   2, 12, 1, 2));
    send_instr(mk_instr(OP_SEQ,   0, 13, 0, 0));
    send_instr(mk_instr(OP_STORE, 0, 2, 0, 1023));
    send_instr(mk_instr(OP_LOAD,  0, 14, 0, 1023));
    send_instr(mk_instr(OP_LOAD,  2, 15, 0, 1));
    send_instr(mk_instr(OP_ADD,   5, 0, 1, 32));
    send_instr(mk_instr(OP_JMP,  16, 0, 0, 15));
    send_instr(mk_instr(OP_JMP,  17, 0, 0, 16));
    send_instr(mk_instr(OP_BRAZ,  0, 0, 0, 3));
    send_instr(mk_instr(OP_BRAZ,  2, 0, 0, 3));
    send_instr(mk_instr(OP_BRANZ, 2, 0, 0, 100));
    send_instr(mk_instr(OP_SCALL, 31, 31, 1, 16'hFFFF));
    send_instr({5'd31, 27'h7FF_FFFF});
    drain_results();

    // random phases over several program lengths
    len_list = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom), 16'd20};
    for (int ph = 0; ph < 5; ph++) begin
      write_prog_len(len_list[ph]);
      quiet_mode = (ph == 4);
      for (int n = 0; n < 170; n++) begin
        if (ph == 1 && n == 20) long_hold_req = 1'b1;
        if (ph == 2 && n == 85) begin
          in_valid_i <= 1'b0;
          while (exec_sb.pending_q.size() != 0) @(posedge clk_i);
        end
        send_instr(rand_instr());
        sender_gap();
      end
      drain_results();
    end

    // halt, then items that must be ignored
    send_instr(mk_instr(OP_STOP, 0, 0, 0, 0));
    send_instr(mk_instr(OP_ADD, 1, 1, 0, 5));
    send_instr(mk_instr(OP_JMP, 3, 0, 0, 0));
    drain_results();

    if (exec_sb.fail_count == 0 && exec_sb.pending_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
